>>> design/sxfr_pkg.sv
// Package for the start-byte framed receiver with XOR check byte.
// Holds the start byte, the default payload length and the controller/datapath bundles.
// No dependencies.
`timescale 1ns / 1ps

package sxfr_pkg;

	// Byte that opens every frame.
	localparam logic [7:0] START_BYTE = 8'hEF;

	// Default number of payload bytes in one frame.
	localparam int PAYLOAD_BYTES_DEF = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_frame; // start of frame: clear position and running XOR
		logic store;     // write the accepted byte and fold it into the XOR
		logic idx_clr;   // clear the position before draining
		logic rd_en;     // issue a payload read at the current position
		logic load_data; // load the read payload byte into the output register
		logic load_err;  // load the checksum-error result into the output register
	} sxfr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_hit; // input byte is the start byte
		logic xor_match; // input byte equals the running XOR
		logic idx_last;  // position points at the final payload byte
		logic out_free;  // output register is empty or is being taken
	} sxfr_sts_t;

endpackage

>>> design/sxfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sxfr_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/sxfr_ctrl.sv
// Controller of the framed receiver: hunts, collects, checks and drains a frame.
// Depends on sxfr_pkg for the command and status bundles.
`timescale 1ns / 1ps

module sxfr_ctrl
	import sxfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  sxfr_sts_t sts,
	output logic      in_ready,
	output sxfr_cmd_t cmd
);

	localparam logic [2:0] ST_HUNT  = 3'd0;
	localparam logic [2:0] ST_DATA  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_LD    = 3'd4;
	localparam logic [2:0] ST_ERR   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       in_fire;

	assign in_ready = (state_q == ST_HUNT) || (state_q == ST_DATA) || (state_q == ST_CHECK);
	assign in_fire  = in_valid && in_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_HUNT: begin
				if (in_fire && sts.start_hit) begin
					cmd.clr_frame = 1'b1;
					state_d       = ST_DATA;
				end
			end
			ST_DATA: begin
				if (in_fire) begin
					cmd.store = 1'b1;
					if (sts.idx_last) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (in_fire) begin
					cmd.idx_clr = 1'b1;
					state_d     = sts.xor_match ? ST_RD : ST_ERR;
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LD;
			end
			ST_LD: begin
				if (sts.out_free) begin
					cmd.load_data = 1'b1;
					state_d       = sts.idx_last ? ST_HUNT : ST_RD;
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.load_err = 1'b1;
					state_d      = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/sxfr_dp.sv
// Datapath of the framed receiver: position counter, running XOR, payload RAM
// and output register. Depends on sxfr_pkg and sxfr_ram.
`timescale 1ns / 1ps

module sxfr_dp
	import sxfr_pkg::*;
#(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_data,
	input  sxfr_cmd_t  cmd,
	output sxfr_sts_t  sts,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_data,
	output logic       out_last,
	output logic       out_status
);

	localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

	logic [IDX_W-1:0] idx_q;
	logic [7:0]       xor_q;
	logic [7:0]       rd_data;
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_last_q;
	logic             out_status_q;

	// Position counter: write index while collecting, read index while draining.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.clr_frame || cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.store || cmd.load_data) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Running XOR of the stored payload bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q <= '0;
		end else if (cmd.clr_frame) begin
			xor_q <= '0;
		end else if (cmd.store) begin
			xor_q <= xor_q ^ in_data;
		end
	end

	// Payload buffer; each frame writes every entry before it is read.
	sxfr_ram #(
		.WIDTH (8),
		.DEPTH (PAYLOAD_BYTES),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(idx_q),
		.wdata(in_data),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_data || cmd.load_err) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			out_data_q   <= rd_data;
			out_last_q   <= sts.idx_last;
			out_status_q <= 1'b0;
		end else if (cmd.load_err) begin
			out_data_q   <= 8'h00;
			out_last_q   <= 1'b1;
			out_status_q <= 1'b1;
		end
	end

	// Status toward the controller.
	assign sts.start_hit = (in_data == START_BYTE);
	assign sts.xor_match = (in_data == xor_q);
	assign sts.idx_last  = (idx_q == IDX_W'(PAYLOAD_BYTES - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

endmodule

>>> design/sop_xor_frame_receiver.sv
// Input: one byte per cycle while hunting, collecting or taking the check byte.
// After a matching check byte the payload drains one byte at a time, each as a
// registered payload RAM read, then an output load that waits for the output
// register to be free. A mismatch gives one error transfer.
// Input is not taken while draining. Asynchronous active-low reset returns to
// hunting and empties the output register; payload RAM contents are not reset.
`timescale 1ns / 1ps

module sop_xor_frame_receiver
	import sxfr_pkg::*;
#(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] payload_byte
	output logic       m_axis_tlast,  // last_of_frame
	output logic       m_axis_tuser   // [0] frame_status
);

	sxfr_cmd_t cmd;
	sxfr_sts_t sts;

	// Frame sequencing.
	sxfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.sts     (sts),
		.in_ready(s_axis_tready),
		.cmd     (cmd)
	);

	// Storage, checksum and output register.
	sxfr_dp #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_status(m_axis_tuser)
	);

endmodule

>>> design/sxfr_chk.sv
// Port-level checker for the framed receiver, bound to the top level.
// Depends only on the top-level port names.
`timescale 1ns / 1ps

module sxfr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       m_axis_tuser
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// An error result is a single, closing, zero byte.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
		else $error("malformed checksum-error result");

	// While a frame is mid-drain no input transfer is taken.
	a_drain_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input taken during payload drain");

endmodule

bind sop_xor_frame_receiver sxfr_chk u_sxfr_chk (.*);

>>> test/sop_xor_frame_receiver_tb.sv
// Self-checking testbench for the start-byte framed receiver with XOR check byte.
// Drives framed and stray bytes, predicts every payload or error transfer and checks them.
// Depends on sxfr_pkg and sop_xor_frame_receiver.
`timescale 1ns / 1ps

module sop_xor_frame_receiver_tb;
	import sxfr_pkg::*;

	localparam int FRAME_LEN = PAYLOAD_BYTES_DEF;

	// Parse phases of the receiver, as the predictor tracks them.
	typedef enum logic [1:0] {
		PHASE_HUNT  = 2'd0,
		PHASE_DATA  = 2'd1,
		PHASE_CHECK = 2'd2
	} rx_phase_t;

	// One output transfer: payload byte, end-of-frame mark and checksum status.
	typedef struct packed {
		logic [7:0] payload;
		logic       last;
		logic       status;
	} frame_out_t;

	typedef logic [7:0] payload_arr_t [FRAME_LEN];

	// Tracks the deframer state and the queue of transfers it still owes.
	class deframer_ledger;
		rx_phase_t  phase;
		logic [6:0] position;
		logic [7:0] run_xor;
		logic [7:0] held_payload [FRAME_LEN];
		frame_out_t owed_q [$];
		int         fail_count;

		function new();
			phase = PHASE_HUNT;
			position = '0;
			run_xor = '0;
			fail_count = 0;
			foreach (held_payload[i]) held_payload[i] = '0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// Advances the predicted state by one accepted input byte.
		function void note_rx_byte(logic [7:0] b);
			case (phase)
				PHASE_DATA: begin
					if (position < FRAME_LEN) begin
						held_payload[position] = b;
						run_xor = run_xor ^ b;
						position = position + 7'd1;
					end
					if (position >= FRAME_LEN) phase = PHASE_CHECK;
				end
				PHASE_CHECK: begin
					phase = PHASE_HUNT;
					if (b == run_xor) begin
						for (int k = 0; k < FRAME_LEN; k++)
							owed_q.push_back('{held_payload[k], k == FRAME_LEN - 1, 1'b0});
					end else begin
						owed_q.push_back('{8'h00, 1'b1, 1'b1});
					end
				end
				default: begin
					// The unused phase code behaves like hunting.
					if (b == START_BYTE) begin
						phase = PHASE_DATA;
						position = '0;
						run_xor = '0;
					end else begin
						phase = PHASE_HUNT;
					end
				end
			endcase
		endfunction

		// Compares one output transfer with the oldest owed transfer.
		function void check_out_byte(logic [7:0] data, logic last, logic status);
			frame_out_t want;
			if (owed_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected data %02h last %0b status %0b",
						$realtime, data, last, status);
				return;
			end
			want = owed_q.pop_front();
			if (want.payload !== data || want.last !== last || want.status !== status) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: expected %02h/%0b/%0b, got %02h/%0b/%0b",
						$realtime, want.payload, want.last, want.status,
						data, last, status);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;
	logic       m_axis_tuser;

	deframer_ledger ledger;
	int send_idle_pct;
	int recv_stall_pct;
	int counted_bytes;

	sop_xor_frame_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Output side: random stalls set at the falling edge, transfers checked at the rising edge.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				ledger.check_out_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	// Offers one byte, with an optional idle gap first, and waits for its transfer.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		ledger.note_rx_byte(b);
		counted_bytes += 1;
	endtask

	function automatic logic [7:0] xor_of(input payload_arr_t pl);
		logic [7:0] acc;
		acc = '0;
		foreach (pl[i]) acc = acc ^ pl[i];
		return acc;
	endfunction

	// Sends a start byte, the payload and the given check byte.
	task automatic send_frame(input payload_arr_t pl, input logic [7:0] chk);
		send_byte(START_BYTE);
		foreach (pl[i]) send_byte(pl[i]);
		send_byte(chk);
	endtask

	// Holds the input back until every owed transfer has come out.
	task automatic drain_outputs();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	// Mix of good frames, bad check bytes, cut-short frames and stray bytes.
	task automatic random_traffic(input int target);
		payload_arr_t pl;
		logic [7:0]   chk;
		int           pick;
		int           fill;
		int           cut;
		while (counted_bytes < target) begin
			pick = $urandom_range(0, 99);
			fill = $urandom_range(0, 19);
			foreach (pl[i]) begin
				case (fill)
					0:       pl[i] = 8'h00;
					1:       pl[i] = 8'hFF;
					2:       pl[i] = START_BYTE;
					default: pl[i] = 8'($urandom_range(0, 255));
				endcase
			end
			if (pick < 10) begin
				// Stray bytes between frames.
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 15) begin
				// Frame cut short; the next start byte lands inside the payload.
				cut = $urandom_range(0, FRAME_LEN - 1);
				send_byte(START_BYTE);
				for (int i = 0; i < cut; i++) send_byte(pl[i]);
			end else if (pick < 30) begin
				chk = xor_of(pl) ^ 8'($urandom_range(1, 255));
				send_frame(pl, chk);
			end else begin
				send_frame(pl, xor_of(pl));
			end
		end
	endtask

	// Main sequence.
	initial begin
		payload_arr_t pl;
		ledger = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		counted_bytes = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: stray bytes at the extremes while hunting.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);

		// Good frame holding 0x00, 0xFF and the start byte, with the XOR forced
		// to the start byte so that the check byte is the start byte.
		foreach (pl[i]) pl[i] = 8'($urandom_range(0, 255));
		pl[0] = 8'h00;
		pl[1] = 8'hFF;
		pl[2] = START_BYTE;
		pl[FRAME_LEN - 1] = 8'h00;
		pl[FRAME_LEN - 1] = xor_of(pl) ^ START_BYTE;
		send_frame(pl, START_BYTE);

		// Start byte as a mismatching check byte.
		pl[FRAME_LEN - 1] = pl[FRAME_LEN - 1] ^ 8'h01;
		send_frame(pl, START_BYTE);
		drain_outputs();

		// Random part, in three idling regimes.
		send_idle_pct = 35;
		recv_stall_pct = 73;
		random_traffic(90);
		drain_outputs();
		random_traffic(150);
		drain_outputs();

		send_idle_pct = 73;
		recv_stall_pct = 35;
		random_traffic(270);
		drain_outputs();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_traffic(360);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (ledger.fail_count == 0 && ledger.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
